// ===== design/ppfm_pkg.sv =====
package ppfm_pkg;

    localparam int TIMER_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 8;

    localparam int TPS_W    = 24;
    localparam int COUNT_W  = 32;
    localparam int FREQ_W   = 32;
    localparam int CAP_W    = 32;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 2;

    localparam logic [TPS_W-1:0]  TPS_RESET    = 24'd1000000;
    localparam logic [APB_AW-1:0] CFG_ADDR_TPS = 2'd0;

    typedef struct packed {
        logic             overflow_event;
        logic             capture_event;
        logic [CAP_W-1:0] capture_value;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0] pulse_total;
        logic [FREQ_W-1:0]  average_frequency;
    } t_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== design/ppfm_div.sv =====
module ppfm_div
    import ppfm_pkg::*;
#(
    parameter int NUM_W = TPS_W + FRAC_BITS_DEF,
    parameter int DEN_W = TIMER_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_stat        o_stat,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    // restoring division, one quotient bit per cycle; numerator shifts out
    // at the top while quotient bits shift in at the bottom
    logic [NUM_W-1:0] r_nq;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_rem_sh = {r_rem, r_nq[NUM_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_den};
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_rem_sh[DEN_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_nq;

endmodule

// ===== design/pulse_period_frequency_meter.sv =====
// channel   dir  handshake                 payload
// in        in   i_in_valid / o_in_ready   i_in  (t_in)
// out       out  o_out_valid / i_out_ready o_out (t_out)
// cfg       in   psel/penable/pwrite       paddr, pwdata, prdata
//
// An item without a usable period goes from idle straight to the output wait;
// a capture with a nonzero period first runs through the bit-serial restoring
// divider. One item is in work at a time; the output register holds
// a finished item while the next one is taken. Reset is synchronous, active
// low, and clears the count, last capture, average and tick rate to defaults.
module pulse_period_frequency_meter
    import ppfm_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int NUM_W = TPS_W + FRAC_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]             r_state;
    logic [TPS_W-1:0]       r_tps;
    logic [COUNT_W-1:0]     r_cnt;
    logic [TIMER_WIDTH-1:0] r_prev;
    logic [FREQ_W-1:0]      r_avg;
    logic                   r_out_valid;
    t_out                   r_out;

    logic                   w_in_acc;
    logic [COUNT_W-1:0]     w_base_cnt;
    logic [TIMER_WIDTH-1:0] w_base_prev;
    logic [FREQ_W-1:0]      w_base_avg;
    logic [TIMER_WIDTH-1:0] w_now;
    logic [TIMER_WIDTH-1:0] w_period;
    logic                   w_start;
    t_div_stat              w_div_stat;
    logic [NUM_W-1:0]       w_quot;
    logic [FREQ_W:0]        w_sum;
    logic                   w_out_free;

    assign pready      = 1'b1;
    assign prdata      = (paddr == CFG_ADDR_TPS) ? APB_DW'(r_tps) : '0;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_base_cnt  = i_in.overflow_event ? '0 : r_cnt;
    assign w_base_prev = i_in.overflow_event ? '0 : r_prev;
    assign w_base_avg  = i_in.overflow_event ? '0 : r_avg;
    assign w_now       = i_in.capture_value[TIMER_WIDTH-1:0];
    assign w_period    = w_now - w_base_prev;
    assign w_start     = w_in_acc && i_in.capture_event && (w_period != '0);
    assign w_sum       = {1'b0, r_avg} + (FREQ_W + 1)'(w_quot);

    ppfm_div #(
        .NUM_W (NUM_W),
        .DEN_W (TIMER_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num   (NUM_W'(r_tps) << FRAC_BITS),
        .i_den   (w_period),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= TPS_RESET;
        end else if (psel && penable && pwrite && pready && paddr == CFG_ADDR_TPS) begin
            r_tps <= pwdata[TPS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_prev      <= '0;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_WAIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_avg <= w_base_avg;
                        if (i_in.capture_event) begin
                            r_prev <= w_now;
                            r_cnt  <= w_base_cnt + 1'b1;
                        end else begin
                            r_prev <= w_base_prev;
                            r_cnt  <= w_base_cnt;
                        end
                        r_state <= w_start ? S_DIV : S_WAIT;
                    end
                end
                S_DIV: begin
                    if (w_div_stat.done) begin
                        r_avg   <= w_sum[FREQ_W:1];
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && w_out_free) begin
            r_out.pulse_total       <= r_cnt;
            r_out.average_frequency <= r_avg;
        end
    end

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_stat.busy && !w_div_stat.done)
        else $error("divider active while idle");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider result outside division state");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_DIV || r_state == S_WAIT))
        else $error("accepted item not processed");

    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !w_div_stat.done) |-> w_div_stat.busy)
        else $error("division state without busy divider");

endmodule

// ===== sim/pulse_period_frequency_meter_tb.sv =====
`timescale 1ns / 100ps

module pulse_period_frequency_meter_tb;
    import ppfm_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 200;
    localparam int FLOOD_ITEMS  = 30;
    localparam int STREAM_ITEMS = 150;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in               i_in;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out              o_out;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // meter state as predicted
    logic [TPS_W-1:0]   tick_rate;
    logic [COUNT_W-1:0] pulse_cnt;
    logic [CAP_W-1:0]   prior_cap;
    logic [FREQ_W-1:0]  avg_freq;

    t_out expected_readings[$];
    int   errors;
    bit   idle_en;
    bit   hold_req;

    pulse_period_frequency_meter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("** pulse_period_frequency_meter: FAILED **");
        $finish;
    end

    function automatic t_out predict_reading(input t_in ev);
        logic [CAP_W-1:0] period;
        logic [63:0]      scaled;
        logic [63:0]      inst_freq;
        logic [FREQ_W:0]  freq_sum;
        t_out             reading;
        if (ev.overflow_event) begin
            pulse_cnt = '0;
            prior_cap = '0;
            avg_freq  = '0;
        end
        if (ev.capture_event) begin
            period    = ev.capture_value - prior_cap;
            prior_cap = ev.capture_value;
            pulse_cnt = pulse_cnt + 1'b1;
            if (period != '0) begin
                scaled    = 64'(tick_rate) << FRAC_BITS_DEF;
                inst_freq = scaled / 64'(period);
                freq_sum  = {1'b0, avg_freq} + {1'b0, inst_freq[FREQ_W-1:0]};
                avg_freq  = freq_sum[FREQ_W:1];
            end
        end
        reading.pulse_total       = pulse_cnt;
        reading.average_frequency = avg_freq;
        return reading;
    endfunction

    function automatic t_in make_random_event();
        t_in         ev;
        int unsigned kind;
        logic [31:0] span;
        kind = $urandom_range(0, 99);
        ev.overflow_event = 1'b0;
        ev.capture_event  = 1'b1;
        ev.capture_value  = $urandom;
        if (kind < 4) begin
            ev.overflow_event = 1'b1;
            ev.capture_event  = 1'b0;
        end else if (kind < 8) begin
            ev.overflow_event = 1'b1;
        end else if (kind < 12) begin
            ev.capture_event = 1'b0;
        end else if (kind < 16) begin
            ev.capture_value = prior_cap;
        end else if (kind >= 26) begin
            case ($urandom_range(0, 3))
                0: span = $urandom_range(1, 16);
                1: span = $urandom_range(17, 4096);
                2: span = $urandom_range(4097, 1 << 20);
                default: span = $urandom;
            endcase
            ev.capture_value = prior_cap + span;
        end
        return ev;
    endfunction

    // valid stays high between back-to-back items unless idle_en inserts a random gap; wait_idle drops it
    task automatic send_event(input t_in ev);
        @(negedge i_clk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= ev;
        do @(posedge i_clk); while (!o_in_ready);
        expected_readings.push_back(predict_reading(ev));
    endtask

    task automatic send_fields(input logic ovf, input logic cap, input logic [CAP_W-1:0] value);
        t_in ev;
        ev.overflow_event = ovf;
        ev.capture_event  = cap;
        ev.capture_value  = value;
        send_event(ev);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_tick_rate();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CFG_ADDR_TPS;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(tick_rate)) begin
            $display("%0t: tick rate readback expected %h got %h",
                     $time, APB_DW'(tick_rate), prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_tick_rate(input logic [TPS_W-1:0] rate);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_TPS;
        pwdata  <= APB_DW'(rate);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tick_rate = rate;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        read_tick_rate();
    endtask

    task automatic test_reset_state();
        read_tick_rate();
        send_fields(1'b0, 1'b0, '0);
        wait_idle();
    endtask

    task automatic test_directed_events();
        send_fields(1'b0, 1'b1, 32'h0000_0000);   // zero period against reset
        send_fields(1'b0, 1'b1, 32'd1000);
        send_fields(1'b0, 1'b1, 32'hFFFF_FFFF);
        send_fields(1'b0, 1'b1, 32'd5);           // period wraps
        send_fields(1'b0, 1'b1, 32'd5);           // zero period
        send_fields(1'b0, 1'b0, 32'hFFFF_FFFF);   // no event
        send_fields(1'b1, 1'b0, 32'hA5A5_A5A5);
        send_fields(1'b1, 1'b1, 32'd100);         // clear, then measure from zero
        send_fields(1'b1, 1'b1, 32'd0);
        send_fields(1'b0, 1'b1, 32'd1);           // shortest period
        wait_idle();
        write_tick_rate(24'hFF_FFFF);
        send_fields(1'b0, 1'b1, 32'd2);
        send_fields(1'b0, 1'b1, 32'hFFFF_FFFF);
        send_fields(1'b0, 1'b1, 32'h8000_0000);
        wait_idle();
        write_tick_rate(24'd0);                   // average halves
        send_fields(1'b0, 1'b1, 32'h8000_0010);
        send_fields(1'b0, 1'b1, 32'h9000_0000);
        send_fields(1'b1, 1'b0, 32'h5A5A_5A5A);
        wait_idle();
        write_tick_rate(24'd1);
        send_fields(1'b0, 1'b1, 32'd1);
        send_fields(1'b0, 1'b1, 32'h7FFF_FFFF);
        send_fields(1'b0, 1'b1, 32'h0000_0000);
        wait_idle();
    endtask

    task automatic test_random_rates();
        logic [TPS_W-1:0] rates [6];
        rates[0] = 24'hFF_FFFF;
        rates[1] = 24'd1;
        rates[2] = 24'd0;
        rates[3] = TPS_W'($urandom);
        rates[4] = TPS_RESET;
        rates[5] = TPS_W'($urandom_range(2, 1000));
        foreach (rates[r]) begin
            write_tick_rate(rates[r]);
            repeat (PHASE_ITEMS) send_event(make_random_event());
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (FLOOD_ITEMS) send_event(make_random_event());
        wait_idle();
    endtask

    task automatic test_streaming();
        idle_en = 1'b0;
        write_tick_rate(TPS_W'($urandom));
        repeat (STREAM_ITEMS) send_event(make_random_event());
        wait_idle();
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected item pulse_total %h average_frequency %h",
                         $time, o_out.pulse_total, o_out.average_frequency);
                errors++;
            end else begin
                want = expected_readings.pop_front();
                if (o_out.pulse_total !== want.pulse_total) begin
                    $display("%0t: pulse_total expected %h got %h",
                             $time, want.pulse_total, o_out.pulse_total);
                    errors++;
                end
                if (o_out.average_frequency !== want.average_frequency) begin
                    $display("%0t: average_frequency expected %h got %h",
                             $time, want.average_frequency, o_out.average_frequency);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors     = 0;
        idle_en    = 1'b1;
        hold_req   = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tick_rate  = TPS_RESET;
        pulse_cnt  = '0;
        prior_cap  = '0;
        avg_freq   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_events();
        test_random_rates();
        test_backpressure();
        test_streaming();

        if (errors == 0) begin
            $display("** pulse_period_frequency_meter: PASSED **");
        end else begin
            $display("** pulse_period_frequency_meter: FAILED **");
        end
        $finish;
    end

endmodule
